FILE: rtl/gsp_pkg.sv
`default_nettype none

package gsp_pkg;

  localparam int unsigned IN_WIDTH    = 32;
  localparam int unsigned OUT_WIDTH   = 43;
  localparam int unsigned N_WIDTH_DEF = 32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TEST,
    S_DIV,
    S_EVAL,
    S_MUL_TERM,
    S_MUL_PW,
    S_MUL_RES,
    S_NEXT,
    S_TAIL,
    S_MUL_TAIL,
    S_OUT
  } state_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_TERM_P,
    MUL_PW_P,
    MUL_RES_TERM,
    MUL_RES_TAIL
  } mul_op_e;

  typedef struct packed {
    logic    load;
    logic    div_load;
    logic    div_step;
    logic    take_quot;
    logic    next_p;
    mul_op_e mul_op;
  } cmd_t;

  typedef struct packed {
    logic psq_le_rest;
    logic div_last;
    logic rem_zero;
    logic pw_one;
    logic mul_done;
    logic rest_gt1;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/gsp_ctrl.sv
`default_nettype none

module gsp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  output logic               done_o,
  output gsp_pkg::cmd_t      cmd_o,
  input  wire gsp_pkg::sts_t sts_i
);
  import gsp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (start_i) state_d = S_TEST;
      S_TEST:     state_d = sts_i.psq_le_rest ? S_DIV : S_TAIL;
      S_DIV:      if (sts_i.div_last) state_d = S_EVAL;
      S_EVAL: begin
        if (sts_i.rem_zero) begin
          state_d = S_MUL_TERM;
        end else if (sts_i.pw_one) begin
          state_d = S_NEXT;
        end else begin
          state_d = S_MUL_RES;
        end
      end
      S_MUL_TERM: if (sts_i.mul_done) state_d = S_MUL_PW;
      S_MUL_PW:   if (sts_i.mul_done) state_d = S_DIV;
      S_MUL_RES:  if (sts_i.mul_done) state_d = S_NEXT;
      S_NEXT:     state_d = S_TEST;
      S_TAIL:     state_d = sts_i.rest_gt1 ? S_MUL_TAIL : S_OUT;
      S_MUL_TAIL: if (sts_i.mul_done) state_d = S_OUT;
      S_OUT:      state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_op    = MUL_NONE;
    busy_o          = 1'b1;
    done_o          = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      S_TEST:     cmd_o.div_load = sts_i.psq_le_rest;
      S_DIV:      cmd_o.div_step = 1'b1;
      S_EVAL:     cmd_o.take_quot = sts_i.rem_zero;
      S_MUL_TERM: cmd_o.mul_op = MUL_TERM_P;
      S_MUL_PW: begin
        cmd_o.mul_op   = MUL_PW_P;
        cmd_o.div_load = sts_i.mul_done;
      end
      S_MUL_RES:  cmd_o.mul_op = MUL_RES_TERM;
      S_NEXT:     cmd_o.next_p = 1'b1;
      S_TAIL:     ;
      S_MUL_TAIL: cmd_o.mul_op = MUL_RES_TAIL;
      S_OUT:      done_o = 1'b1;
      default:    ;
    endcase
  end

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe lasted more than one cycle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not make the block busy");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && sts_i.div_last) |=> state_q == S_EVAL)
    else $error("division did not end in evaluation");

endmodule

`default_nettype wire

FILE: rtl/gsp_dp.sv
`default_nettype none

module gsp_dp #(
  parameter int unsigned N_WIDTH = gsp_pkg::N_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [gsp_pkg::IN_WIDTH-1:0]  n_i,
  input  wire gsp_pkg::cmd_t                 cmd_i,
  output gsp_pkg::sts_t                      sts_o,
  output logic [gsp_pkg::OUT_WIDTH-1:0]      gcd_sum_o
);
  import gsp_pkg::*;

  localparam int unsigned PW  = (N_WIDTH + 1) / 2 + 1;
  localparam int unsigned SQW = N_WIDTH + 2;
  localparam int unsigned CW  = $clog2(N_WIDTH);
  localparam int unsigned OW  = OUT_WIDTH;

  logic [N_WIDTH-1:0] rest_q, rest_d;
  logic [PW-1:0]      p_q, p_d;
  logic [SQW-1:0]     psq_q, psq_d;
  logic [N_WIDTH-1:0] dvd_q, dvd_d;
  logic [PW-1:0]      rem_q, rem_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [OW-1:0]      term_q, term_d;
  logic [OW-1:0]      pw_q, pw_d;
  logic [OW-1:0]      res_q, res_d;
  logic [OW-1:0]      mul_a_q, mul_a_d;
  logic [OW-1:0]      mul_b_q, mul_b_d;
  logic [OW-1:0]      mul_acc_q, mul_acc_d;
  logic               mul_run_q, mul_run_d;

  logic [N_WIDTH-1:0] n_masked;
  logic [PW:0]        rem_sh;
  logic               rem_ge;
  logic [N_WIDTH:0]   tail;
  logic [OW-1:0]      op_a, op_b;
  logic               mul_fin;

  assign n_masked = n_i[N_WIDTH-1:0];
  assign rem_sh   = {rem_q, dvd_q[N_WIDTH-1]};
  assign rem_ge   = rem_sh >= {1'b0, p_q};
  assign tail     = {rest_q, 1'b0} - (N_WIDTH + 1)'(1);
  assign mul_fin  = mul_run_q && (mul_b_q == '0);

  always_comb begin
    case (cmd_i.mul_op)
      MUL_TERM_P: begin
        op_a = term_q;
        op_b = OW'(p_q);
      end
      MUL_PW_P: begin
        op_a = pw_q;
        op_b = OW'(p_q);
      end
      MUL_RES_TERM: begin
        op_a = res_q;
        op_b = term_q;
      end
      MUL_RES_TAIL: begin
        op_a = res_q;
        op_b = OW'(tail);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    rest_d    = rest_q;
    p_d       = p_q;
    psq_d     = psq_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    term_d    = term_q;
    pw_d      = pw_q;
    res_d     = res_q;
    mul_a_d   = mul_a_q;
    mul_b_d   = mul_b_q;
    mul_acc_d = mul_acc_q;
    mul_run_d = mul_run_q;

    if (cmd_i.load) begin
      rest_d = n_masked;
      res_d  = (n_masked == '0) ? '0 : OW'(1);
      p_d    = PW'(2);
      psq_d  = SQW'(4);
      term_d = OW'(1);
      pw_d   = OW'(1);
    end

    if (cmd_i.div_load) begin
      dvd_d = rest_q;
      rem_d = '0;
      cnt_d = '0;
    end else if (cmd_i.div_step) begin
      dvd_d = {dvd_q[N_WIDTH-2:0], rem_ge};
      rem_d = rem_ge ? rem_sh[PW-1:0] - p_q : rem_sh[PW-1:0];
      cnt_d = cnt_q + CW'(1);
    end

    if (cmd_i.take_quot) begin
      rest_d = dvd_q;
    end

    if (cmd_i.next_p) begin
      p_d    = p_q + PW'(1);
      psq_d  = psq_q + SQW'({p_q, 1'b0}) + SQW'(1);
      term_d = OW'(1);
      pw_d   = OW'(1);
    end

    if (cmd_i.mul_op != MUL_NONE) begin
      if (!mul_run_q) begin
        mul_a_d   = op_a;
        mul_b_d   = op_b;
        mul_acc_d = '0;
        mul_run_d = 1'b1;
      end else if (mul_fin) begin
        mul_run_d = 1'b0;
        case (cmd_i.mul_op) inside
          MUL_TERM_P: term_d = mul_acc_q;
          MUL_PW_P: begin
            pw_d   = mul_acc_q;
            term_d = term_q + mul_acc_q - pw_q;
          end
          MUL_RES_TERM,
          MUL_RES_TAIL: res_d = mul_acc_q;
          default: ;
        endcase
      end else begin
        if (mul_b_q[0]) begin
          mul_acc_d = mul_acc_q + mul_a_q;
        end
        mul_a_d = {mul_a_q[OW-2:0], 1'b0};
        mul_b_d = {1'b0, mul_b_q[OW-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q    <= '0;
      p_q       <= PW'(2);
      psq_q     <= SQW'(4);
      dvd_q     <= '0;
      rem_q     <= '0;
      cnt_q     <= '0;
      term_q    <= OW'(1);
      pw_q      <= OW'(1);
      res_q     <= '0;
      mul_a_q   <= '0;
      mul_b_q   <= '0;
      mul_acc_q <= '0;
      mul_run_q <= 1'b0;
    end else begin
      rest_q    <= rest_d;
      p_q       <= p_d;
      psq_q     <= psq_d;
      dvd_q     <= dvd_d;
      rem_q     <= rem_d;
      cnt_q     <= cnt_d;
      term_q    <= term_d;
      pw_q      <= pw_d;
      res_q     <= res_d;
      mul_a_q   <= mul_a_d;
      mul_b_q   <= mul_b_d;
      mul_acc_q <= mul_acc_d;
      mul_run_q <= mul_run_d;
    end
  end

  assign sts_o.psq_le_rest = psq_q <= SQW'(rest_q);
  assign sts_o.div_last    = cnt_q == CW'(N_WIDTH - 1);
  assign sts_o.rem_zero    = rem_q == '0;
  assign sts_o.pw_one      = pw_q == OW'(1);
  assign sts_o.mul_done    = mul_fin;
  assign sts_o.rest_gt1    = rest_q > N_WIDTH'(1);

  assign gcd_sum_o = res_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> rem_q < p_q)
    else $error("division remainder not below the trial divisor");

  a_square_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psq_q == SQW'(p_q) * SQW'(p_q))
    else $error("running square lost track of the trial divisor");

  a_mul_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_fin |=> !mul_run_q)
    else $error("multiplier did not release after writeback");

endmodule

`default_nettype wire

FILE: rtl/gcd_sum_pillai.sv
// Computes the gcd sum of n (sum of gcd(k, n) for k = 1 .. n) from the low N_WIDTH bits of
// n_i, which is accepted when start is high while busy is low. The result is held on
// gcd_sum_o until the next word is loaded, and done_o is high for exactly one cycle; the
// receiver cannot stall it. The block factors n by trial division with a bit-serial
// divider. Each division that finds a factor adds two shift-add multiplications and each
// distinct prime factor one more. The run time therefore grows with the square root of
// the largest remaining cofactor: it is longest for a prime n, far shorter for numbers
// with small factors, and shortest for n = 0 or 1. One word is processed at a time.
`default_nettype none

module gcd_sum_pillai #(
  parameter int unsigned N_WIDTH = gsp_pkg::N_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [gsp_pkg::IN_WIDTH-1:0]  n_i,
  output logic                               done_o,
  output logic [gsp_pkg::OUT_WIDTH-1:0]      gcd_sum_o
);
  import gsp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gsp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  gsp_dp #(
    .N_WIDTH (N_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .n_i       (n_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .gcd_sum_o (gcd_sum_o)
  );

endmodule

`default_nettype wire
